// ===== hw/rtl/cpc_pkg.sv =====
package cpc_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int COORD_BITS_DEF   = 16;

  localparam int COUNT_W  = 6;
  localparam int MARGIN_W = 12;
  localparam int INDEX_W  = 5;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 1;

  localparam int MIN_VERTICES = 3;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAFETY_MARGIN = 1'b1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Control between the sequencer and the edge pipeline.
  typedef struct packed {
    logic issue;
    logic clear;
  } cpc_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } cpc_state_t;

endpackage

// ===== hw/rtl/cpc_cell.sv =====
module cpc_cell import cpc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  shift,
  input  logic                  load,
  input  logic [COORD_BITS-1:0] nbr_x,
  input  logic [COORD_BITS-1:0] nbr_y,
  input  logic [COORD_BITS-1:0] wr_x,
  input  logic [COORD_BITS-1:0] wr_y,
  output logic [COORD_BITS-1:0] x,
  output logic [COORD_BITS-1:0] y
);

  always_ff @(posedge clk) begin
    if (load) begin
      x <= wr_x;
      y <= wr_y;
    end else if (shift) begin
      x <= nbr_x;
      y <= nbr_y;
    end
  end

endmodule

// ===== hw/rtl/cpc_edge_unit.sv =====
module cpc_edge_unit import cpc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cpc_ctl_t                   ctl,
  input  logic [COORD_BITS-1:0]      ax,
  input  logic [COORD_BITS-1:0]      ay,
  input  logic [COORD_BITS-1:0]      bx,
  input  logic [COORD_BITS-1:0]      by,
  input  logic [COORD_BITS-1:0]      px,
  input  logic [COORD_BITS-1:0]      py,
  input  logic [2*MARGIN_W-1:0]      msq,
  output logic                       fail
);

  localparam int D  = COORD_BITS + 1;
  localparam int P  = 2 * D;
  localparam int X  = P + 1;
  localparam int LO = X / 2;
  localparam int HI = X - LO;
  localparam int MT = P + 1 + 2 * MARGIN_W;
  localparam int WC = (2 * X > MT) ? 2 * X : MT;

  logic                v1, v2, v3, v4;
  logic signed [D-1:0] ex, ey, dx, dy;
  logic signed [P-1:0] pxy, pyx, exx, eyy;
  logic                zero2, zero3, zero4;
  logic [X-1:0]        cmag;
  logic                neg3, neg4;
  logic [P:0]          len2;
  logic [X+LO-1:0]     cc_lo;
  logic [X+HI-1:0]     cc_hi;
  logic [P+MARGIN_W:0] ml, mh;
  logic signed [X-1:0] xprod;
  logic [WC-1:0]       csq, mterm;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign xprod = X'(pxy) - X'(pyx);

  always_ff @(posedge clk) begin
    ex <= D'($signed(bx)) - D'($signed(ax));
    ey <= D'($signed(by)) - D'($signed(ay));
    dx <= D'($signed(px)) - D'($signed(ax));
    dy <= D'($signed(py)) - D'($signed(ay));

    pxy   <= P'(ex) * P'(dy);
    pyx   <= P'(ey) * P'(dx);
    exx   <= P'(ex) * P'(ex);
    eyy   <= P'(ey) * P'(ey);
    zero2 <= (ex == '0) && (ey == '0);

    neg3  <= xprod[X-1];
    cmag  <= xprod[X-1] ? X'(-xprod) : X'(xprod);
    len2  <= (P+1)'($unsigned(exx)) + (P+1)'($unsigned(eyy));
    zero3 <= zero2;

    // The squared cross product and the margin term are each split into two partial products.
    cc_lo <= (X+LO)'(cmag) * (X+LO)'(cmag[LO-1:0]);
    cc_hi <= (X+HI)'(cmag) * (X+HI)'(cmag[X-1:LO]);
    ml    <= (P+MARGIN_W+1)'(len2) * (P+MARGIN_W+1)'(msq[MARGIN_W-1:0]);
    mh    <= (P+MARGIN_W+1)'(len2) * (P+MARGIN_W+1)'(msq[2*MARGIN_W-1:MARGIN_W]);
    neg4  <= neg3;
    zero4 <= zero3;
  end

  assign csq   = (WC'(cc_hi) << LO) + WC'(cc_lo);
  assign mterm = (WC'(mh) << MARGIN_W) + WC'(ml);
  assign fail  = v4 && neg4 && !zero4 && (csq > mterm);

endmodule

// ===== hw/rtl/convex_polygon_containment.sv =====
// Point-in-convex-polygon test with an outward safety margin.
// Input transactions are taken at a rising edge where start is high and busy
// is low. A write transaction (command 0) stores coord_x/coord_y in slot
// vertex_index and is acknowledged by done in the next cycle, with
// answered_query and inside_res low; the block is ready again at once.
// A query transaction (command 1) tests the point against the polygon held
// in the vertex ring. The ring rotates once, one vertex per cycle, into the
// edge pipeline, so a query holds busy until the ring has rotated and the
// pipeline has drained, and its result appears as busy falls; the busy time
// is set by the ring length (MAX_VERTICES), not by vertex_count.
// Each result is shown for one cycle with done high; the receiver cannot
// stall it. Configuration registers (vertex_count, safety_margin) are
// written through cfg_write/cfg_index/cfg_data and must change only while
// the block is idle. Reset clears the control state and both registers; the
// vertex slots hold no defined value until written.
module convex_polygon_containment import cpc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  command,
  input  logic [INDEX_W-1:0]    vertex_index,
  input  logic [COORD_BITS-1:0] coord_x,
  input  logic [COORD_BITS-1:0] coord_y,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  done,
  output logic                  answered_query,
  output logic                  inside_res
);

  localparam int PIPE = 5;
  localparam int CW   = $clog2(MAX_VERTICES + PIPE + 1);

  cpc_state_t            state;
  logic [CW-1:0]         cnt;
  logic [COUNT_W-1:0]    vertex_count;
  logic [MARGIN_W-1:0]   safety_margin;
  logic [2*MARGIN_W-1:0] msq;
  logic [COORD_BITS-1:0] px, py, prev_x, prev_y, first_x, first_y;
  logic [COORD_BITS-1:0] cx [MAX_VERTICES];
  logic [COORD_BITS-1:0] cy [MAX_VERTICES];
  logic [CW-1:0]         n_eff;
  logic                  accept, shift, last, outside, fail;
  logic [COORD_BITS-1:0] bx, by;
  cpc_ctl_t              ctl;

  assign busy   = (state == S_RUN);
  assign accept = start && !busy;
  assign shift  = busy && (cnt < CW'(MAX_VERTICES));
  assign last   = busy && (cnt == CW'(MAX_VERTICES + PIPE));
  assign n_eff  = (32'(vertex_count) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                          : CW'(vertex_count);

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_ring
    cpc_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk   (clk),
      .shift (shift),
      .load  (accept && (command == CMD_WRITE) && (32'(vertex_index) == 32'(i))),
      .nbr_x (cx[(i + 1) % MAX_VERTICES]),
      .nbr_y (cy[(i + 1) % MAX_VERTICES]),
      .wr_x  (coord_x),
      .wr_y  (coord_y),
      .x     (cx[i]),
      .y     (cy[i])
    );
  end

  // The closing edge runs from the last vertex back to the first one.
  assign bx = (cnt == n_eff) ? first_x : cx[0];
  assign by = (cnt == n_eff) ? first_y : cy[0];

  assign ctl.issue = busy && (cnt != '0) && (cnt <= n_eff);
  assign ctl.clear = accept;

  cpc_edge_unit #(.COORD_BITS(COORD_BITS)) u_edge (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .ax   (prev_x),
    .ay   (prev_y),
    .bx   (bx),
    .by   (by),
    .px   (px),
    .py   (py),
    .msq  (msq),
    .fail (fail)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= '0;
      safety_margin <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VERTEX_COUNT:  vertex_count  <= cfg_data[COUNT_W-1:0];
        REG_SAFETY_MARGIN: safety_margin <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    msq    <= (2*MARGIN_W)'(safety_margin) * (2*MARGIN_W)'(safety_margin);
    prev_x <= cx[0];
    prev_y <= cy[0];
    if (busy && (cnt == '0)) begin
      first_x <= cx[0];
      first_y <= cy[0];
    end
    if (accept) begin
      px <= coord_x;
      py <= coord_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      outside        <= 1'b0;
      done           <= 1'b0;
      answered_query <= 1'b0;
      inside_res     <= 1'b0;
    end else begin
      done           <= 1'b0;
      answered_query <= 1'b0;
      inside_res     <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (command == CMD_QUERY) begin
              state   <= S_RUN;
              cnt     <= '0;
              outside <= 1'b0;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_RUN: begin
          if (fail) begin
            outside <= 1'b1;
          end
          if (last) begin
            state          <= S_IDLE;
            done           <= 1'b1;
            answered_query <= 1'b1;
            inside_res     <= (n_eff >= CW'(MIN_VERTICES)) && !outside;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/tb_convex_polygon_containment.sv =====
module tb_convex_polygon_containment;
  import cpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Holds the polygon as the block should see it and the answers still owed.
  class containment_scoreboard;
    logic signed [15:0] poly_x[32];
    logic signed [15:0] poly_y[32];
    int unsigned count_reg;
    int unsigned margin_reg;
    bit [1:0] answer_q[$];
    int errors;

    function new();
      count_reg = 0;
      margin_reg = 0;
      errors = 0;
      for (int i = 0; i < 32; i++) begin
        poly_x[i] = '0;
        poly_y[i] = '0;
      end
    endfunction

    function bit point_within(logic signed [15:0] px, logic signed [15:0] py);
      int unsigned n;
      int unsigned j;
      longint ex, ey, crs, len2, mag;
      logic [127:0] lhs, rhs;
      n = (count_reg > 32) ? 32 : count_reg;
      if (n < MIN_VERTICES) return 1'b0;
      for (int unsigned i = 0; i < n; i++) begin
        j = (i + 1 == n) ? 0 : i + 1;
        ex = longint'(poly_x[j]) - longint'(poly_x[i]);
        ey = longint'(poly_y[j]) - longint'(poly_y[i]);
        if (ex == 0 && ey == 0) continue;
        crs = ex * (longint'(py) - longint'(poly_y[i]))
            - ey * (longint'(px) - longint'(poly_x[i]));
        if (crs >= 0) continue;
        mag = -crs;
        len2 = ex * ex + ey * ey;
        lhs = 128'(mag) * 128'(mag);
        rhs = 128'(longint'(margin_reg) * longint'(margin_reg)) * 128'(len2);
        if (lhs > rhs) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_input(logic cmd, logic [4:0] idx, logic signed [15:0] x,
                             logic signed [15:0] y);
      if (cmd == CMD_WRITE) begin
        poly_x[idx] = x;
        poly_y[idx] = y;
        answer_q.insert(answer_q.size(), 2'b00);
      end else begin
        answer_q.insert(answer_q.size(), {1'b1, point_within(x, y)});
      end
    endfunction

    function void check_result(logic aq, logic ins);
      bit [1:0] exp_r;
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result answered_query=%b inside_res=%b", $time, aq, ins);
        errors++;
        return;
      end
      exp_r = answer_q.pop_front();
      if (aq !== exp_r[1]) begin
        $display("%0t: answered_query expected %b actual %b", $time, exp_r[1], aq);
        errors++;
      end
      if (ins !== exp_r[0]) begin
        $display("%0t: inside_res expected %b actual %b", $time, exp_r[0], ins);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic command = CMD_WRITE;
  logic [INDEX_W-1:0] vertex_index = '0;
  logic [15:0] coord_x = '0;
  logic [15:0] coord_y = '0;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_VERTEX_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done;
  logic answered_query;
  logic inside_res;

  containment_scoreboard sb = new();
  int idle_cycles = 0;
  real cen_x, cen_y, radius;

  convex_polygon_containment uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .vertex_index(vertex_index), .coord_x(coord_x), .coord_y(coord_y),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .answered_query(answered_query), .inside_res(inside_res)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(answered_query, inside_res);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 3000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] clamp16(real v);
    if (v > 32767.0) return 16'sd32767;
    if (v < -32768.0) return 16'h8000;
    return 16'($rtoi(v));
  endfunction

  // Drives one transaction and returns at the edge where it is taken.
  task automatic send(logic cmd, logic [4:0] idx, logic [15:0] x, logic [15:0] y);
    @(negedge clk);
    start = 1'b1;
    command = cmd;
    vertex_index = idx;
    coord_x = x;
    coord_y = y;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_input(cmd, idx, x, y);
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) pause(0);
    else if (r < 9) pause($urandom_range(1, 4));
    else pause($urandom_range(10, 60));
  endtask

  task automatic drain();
    pause(1);
    while (sb.answer_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  // Registers change only with the block drained and idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    drain();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(value);
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_VERTEX_COUNT) sb.count_reg = value & 6'h3F;
    else sb.margin_reg = value & 12'hFFF;
  endtask

  task automatic load_polygon(int unsigned n);
    real ang;
    logic [15:0] px, py;
    cen_x = $itor($signed($urandom_range(0, 16000))) - 8000.0;
    cen_y = $itor($signed($urandom_range(0, 16000))) - 8000.0;
    radius = ($urandom_range(0, 3) == 0) ? $itor($urandom_range(1, 40))
                                         : $itor($urandom_range(100, 24000));
    for (int i = 0; i < n; i++) begin
      ang = 6.2831853 * (i + 0.4 * ($urandom_range(0, 100) / 100.0)) / n;
      px = clamp16(cen_x + radius * $cos(ang));
      py = clamp16(cen_y + radius * $sin(ang));
      // A repeated vertex gives a zero-length edge.
      if (i > 0 && $urandom_range(0, 7) == 0) begin
        px = sb.poly_x[i - 1];
        py = sb.poly_y[i - 1];
      end
      send(CMD_WRITE, 5'(i), px, py);
      random_gap();
    end
  endtask

  task automatic random_item(int unsigned n);
    int r;
    int unsigned k;
    real sc;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      sc = 1.3 * radius + 5000.0;
      send(CMD_QUERY, 5'($urandom),
           clamp16(cen_x + sc * ($urandom_range(0, 2000) / 1000.0 - 1.0)),
           clamp16(cen_y + sc * ($urandom_range(0, 2000) / 1000.0 - 1.0)));
    end else if (r < 80) begin
      k = $urandom_range(0, n - 1);
      send(CMD_QUERY, 5'($urandom), sb.poly_x[k] + 16'($urandom_range(0, 2)) - 16'd1,
           sb.poly_y[k] + 16'($urandom_range(0, 2)) - 16'd1);
    end else if (r < 90) begin
      send(CMD_QUERY, 5'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      send(CMD_WRITE, 5'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int unsigned counts[14] = '{3, 4, 32, 63, 0, 2, 5, 33, 8, 6, 12, 32, 3, 20};
    int unsigned n_used;
    int unsigned mval;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part.
    write_reg(REG_VERTEX_COUNT, 0);
    write_reg(REG_SAFETY_MARGIN, 0);
    send(CMD_QUERY, 5'd0, 16'd0, 16'd0);
    send(CMD_WRITE, 5'd0, 16'h8000, 16'h8000);
    send(CMD_WRITE, 5'd1, 16'h7FFF, 16'h8000);
    send(CMD_WRITE, 5'd2, 16'h7FFF, 16'h7FFF);
    send(CMD_WRITE, 5'd3, 16'h8000, 16'h7FFF);
    send(CMD_WRITE, 5'd4, 16'h8000, 16'h7FFF);
    write_reg(REG_VERTEX_COUNT, 5);
    send(CMD_QUERY, 5'd31, 16'd0, 16'd0);
    send(CMD_QUERY, 5'd0, 16'h7FFF, 16'h7FFF);
    send(CMD_QUERY, 5'd0, 16'h8000, 16'h8000);
    send(CMD_WRITE, 5'd0, 16'd0, 16'd0);
    send(CMD_WRITE, 5'd1, 16'd4096, 16'd0);
    send(CMD_WRITE, 5'd2, 16'd0, 16'd4096);
    write_reg(REG_VERTEX_COUNT, 3);
    send(CMD_QUERY, 5'd0, 16'hFFFF, 16'd0);
    send(CMD_QUERY, 5'd0, 16'd2048, 16'd2048);
    send(CMD_QUERY, 5'd0, 16'd1000, 16'd1000);
    write_reg(REG_SAFETY_MARGIN, 4095);
    send(CMD_QUERY, 5'd0, -16'sd4095, 16'd100);
    send(CMD_QUERY, 5'd0, -16'sd4097, 16'd100);
    send(CMD_QUERY, 5'd0, 16'h8000, 16'h8000);
    send(CMD_WRITE, 5'd1, 16'd0, 16'd0);
    send(CMD_WRITE, 5'd2, 16'd0, 16'd0);
    send(CMD_QUERY, 5'd0, 16'h7FFF, 16'h8000);
    write_reg(REG_VERTEX_COUNT, 2);
    send(CMD_QUERY, 5'd0, 16'd0, 16'd0);

    // Random part, one polygon and register setting per phase.
    for (int ph = 0; ph < 14; ph++) begin
      mval = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 4095 : $urandom_range(1, 4094);
      if (ph % 4 == 3) mval = $urandom_range(0, 64);
      write_reg(REG_SAFETY_MARGIN, mval);
      write_reg(REG_VERTEX_COUNT, counts[ph]);
      n_used = (counts[ph] > 32) ? 32 : counts[ph];
      if (n_used < 3) n_used = 3;
      load_polygon(n_used);
      for (int k = 0; k < 65; k++) begin
        random_item(n_used);
        if (ph == 6 && k == 30) begin
          pause(1);
          while (sb.answer_q.size() != 0) @(posedge clk);
        end else begin
          random_gap();
        end
      end
    end

    drain();
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/cpc_pkg.sv
hw/rtl/cpc_cell.sv
hw/rtl/cpc_edge_unit.sv
hw/rtl/convex_polygon_containment.sv
dv/tb_convex_polygon_containment.sv
